### src/ias_pkg.sv
// ----------------------------------------------------------------------------
// ias_pkg: shared types and constants for the intruder alarm sequencer
// Register indexes, reset values and the item structs that pass between the
// configuration block, the sequencing core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ias_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_EXIT_DELAY   = 3'd0,
      CSR_ENTRY_DELAY  = 3'd1,
      CSR_SIREN_TIME   = 3'd2,
      CSR_REPEAT_PAUSE = 3'd3,
      CSR_REPEAT_LIMIT = 3'd4
   } csr_index_type;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned REPEAT_WIDTH   = 4;
   localparam int unsigned REQ_DATA_WIDTH = 8;
   localparam int unsigned RSP_DATA_WIDTH = 16;

   // reset values of the timing registers, in ms
   localparam logic [31:0] EXIT_DELAY_RST   = 32'd30000;
   localparam logic [31:0] ENTRY_DELAY_RST  = 32'd15000;
   localparam logic [31:0] SIREN_TIME_RST   = 32'd180000;
   localparam logic [31:0] REPEAT_PAUSE_RST = 32'd60000;
   localparam logic [REPEAT_WIDTH-1:0] REPEAT_LIMIT_RST = 4'd3;

   // one input tick
   typedef struct packed {
      logic disarm_cmd;
      logic start_cmd;
      logic sensor_active;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic [REPEAT_WIDTH-1:0] repeats_done;
      logic                    intrusion_off_event;
      logic                    intrusion_on_event;
      logic                    armed_event;
      logic                    armed;
      logic                    siren;
   } rsp_item_type;

endpackage

`default_nettype wire

### src/intruder_alarm_sequencer.sv
// ----------------------------------------------------------------------------
// intruder_alarm_sequencer: exit/entry delay and siren burst sequencer
// Top level: input register, sequencing core and result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per millisecond tick (sensor level, start and
//   disarm commands). rsp_* returns exactly one result item per input item:
//   siren and armed levels after the tick, the arming, burst-start and
//   burst-end/disarm events, and the repeat count of the current alarm cycle.
//   csr_* writes the timing registers (index 0..4); the user must write
//   them only while idle, which the block itself does not enforce.
//   An accepted item sits in the input register until the result register
//   is free or draining; the core then sequences it and the result register
//   takes its result at the same edge. One item per cycle is sustained while
//   rsp_tready stays high. The only loop is the single-tick core state update.
// Reset:
//   Synchronous reset clears all timers and flags, empties both registers
//   and loads the register defaults (30000, 15000, 180000, 60000, 3).
// Stall:
//   While rsp_tready is low the result is held; the input register still
//   takes one more item, then req_tready drops until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module intruder_alarm_sequencer #(
   parameter int unsigned TIMER_WIDTH = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input items
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [0] sensor_active, [1] start_cmd, [2] disarm_cmd, [7:3] zero
   input  wire logic [ias_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // result items
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] siren, [1] armed, [2] armed_event, [3] intrusion_on_event,
   // [4] intrusion_off_event, [8:5] repeats_done, [15:9] zero
   output logic      [ias_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // configuration writes
   input  wire logic                                csr_we,
   input  wire logic [ias_pkg::CSR_ADDR_WIDTH-1:0]  csr_waddr,
   input  wire logic [TIMER_WIDTH-1:0]              csr_wdata
);

   localparam int unsigned RSP_BITS = $bits(ias_pkg::rsp_item_type);

   logic                             in_valid_ff;
   ias_pkg::req_item_type            in_item_ff;
   logic                             rsp_valid_ff;
   ias_pkg::rsp_item_type            rsp_item_ff;
   logic                             step_en;
   ias_pkg::rsp_item_type            result;
   logic                             armed_state, entry_state, siren_state;
   logic [TIMER_WIDTH-1:0]           exit_delay, entry_delay, siren_time, repeat_pause;
   logic [ias_pkg::REPEAT_WIDTH-1:0] repeat_limit;

   // the held item moves on when the result register is free or draining
   assign step_en    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.sensor_active <= req_tdata[0];
         in_item_ff.start_cmd     <= req_tdata[1];
         in_item_ff.disarm_cmd    <= req_tdata[2];
      end
   end

   ias_csr #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_waddr    (csr_waddr),
      .csr_wdata    (csr_wdata),
      .exit_delay   (exit_delay),
      .entry_delay  (entry_delay),
      .siren_time   (siren_time),
      .repeat_pause (repeat_pause),
      .repeat_limit (repeat_limit)
   );

   ias_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .item         (in_item_ff),
      .exit_delay   (exit_delay),
      .entry_delay  (entry_delay),
      .siren_time   (siren_time),
      .repeat_pause (repeat_pause),
      .repeat_limit (repeat_limit),
      .result       (result),
      .armed_state  (armed_state),
      .entry_state  (entry_state),
      .siren_state  (siren_state)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ias_pkg::RSP_DATA_WIDTH - RSP_BITS){1'b0}}, rsp_item_ff};

   // siren only sounds while armed
   a_siren_armed: assert property (@(posedge clock) disable iff (reset)
      siren_state |-> armed_state)
      else $error("siren on while disarmed");

   // entry delay only runs while armed
   a_entry_armed: assert property (@(posedge clock) disable iff (reset)
      entry_state |-> armed_state)
      else $error("entry delay running while disarmed");

   // arming and burst start never fall on the same tick
   a_event_excl: assert property (@(posedge clock) disable iff (reset)
      step_en |-> !(result.armed_event && result.intrusion_on_event))
      else $error("arming and burst start on one tick");

endmodule

`default_nettype wire

### src/ias_csr.sv
// ----------------------------------------------------------------------------
// ias_csr: configuration registers
// Holds the delay, siren and repeat settings written through the plain
// write port; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ias_csr #(
   parameter int unsigned TIMER_WIDTH = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [ias_pkg::CSR_ADDR_WIDTH-1:0]  csr_waddr,
   input  wire logic [TIMER_WIDTH-1:0]              csr_wdata,
   output logic      [TIMER_WIDTH-1:0]              exit_delay,
   output logic      [TIMER_WIDTH-1:0]              entry_delay,
   output logic      [TIMER_WIDTH-1:0]              siren_time,
   output logic      [TIMER_WIDTH-1:0]              repeat_pause,
   output logic      [ias_pkg::REPEAT_WIDTH-1:0]    repeat_limit
);

   logic [TIMER_WIDTH-1:0]           exit_delay_ff;
   logic [TIMER_WIDTH-1:0]           entry_delay_ff;
   logic [TIMER_WIDTH-1:0]           siren_time_ff;
   logic [TIMER_WIDTH-1:0]           repeat_pause_ff;
   logic [ias_pkg::REPEAT_WIDTH-1:0] repeat_limit_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         exit_delay_ff   <= TIMER_WIDTH'(ias_pkg::EXIT_DELAY_RST);
         entry_delay_ff  <= TIMER_WIDTH'(ias_pkg::ENTRY_DELAY_RST);
         siren_time_ff   <= TIMER_WIDTH'(ias_pkg::SIREN_TIME_RST);
         repeat_pause_ff <= TIMER_WIDTH'(ias_pkg::REPEAT_PAUSE_RST);
         repeat_limit_ff <= ias_pkg::REPEAT_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_waddr)
            ias_pkg::CSR_EXIT_DELAY:   exit_delay_ff   <= csr_wdata;
            ias_pkg::CSR_ENTRY_DELAY:  entry_delay_ff  <= csr_wdata;
            ias_pkg::CSR_SIREN_TIME:   siren_time_ff   <= csr_wdata;
            ias_pkg::CSR_REPEAT_PAUSE: repeat_pause_ff <= csr_wdata;
            ias_pkg::CSR_REPEAT_LIMIT: repeat_limit_ff <= csr_wdata[ias_pkg::REPEAT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign exit_delay   = exit_delay_ff;
   assign entry_delay  = entry_delay_ff;
   assign siren_time   = siren_time_ff;
   assign repeat_pause = repeat_pause_ff;
   assign repeat_limit = repeat_limit_ff;

endmodule

`default_nettype wire

### src/ias_core.sv
// ----------------------------------------------------------------------------
// ias_core: alarm sequencing state and per-tick update
// Advances the exit, entry and siren timers by one tick and applies disarm,
// start, sensor and expiry rules in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ias_core #(
   parameter int unsigned TIMER_WIDTH = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             step_en,
   input  wire ias_pkg::req_item_type            item,
   input  wire logic [TIMER_WIDTH-1:0]           exit_delay,
   input  wire logic [TIMER_WIDTH-1:0]           entry_delay,
   input  wire logic [TIMER_WIDTH-1:0]           siren_time,
   input  wire logic [TIMER_WIDTH-1:0]           repeat_pause,
   input  wire logic [ias_pkg::REPEAT_WIDTH-1:0] repeat_limit,
   output ias_pkg::rsp_item_type                 result,
   output logic                                  armed_state,
   output logic                                  entry_state,
   output logic                                  siren_state
);

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   logic                             armed_ff, armed_in;
   logic                             exit_run_ff, exit_run_in;
   logic [TIMER_WIDTH-1:0]           exit_el_ff, exit_el_in;
   logic                             entry_run_ff, entry_run_in;
   logic [TIMER_WIDTH:0]             entry_rem_ff, entry_rem_in;
   logic                             siren_ff, siren_in;
   logic                             cycle_ff, cycle_in;
   logic [TIMER_WIDTH-1:0]           siren_el_ff, siren_el_in;
   logic [ias_pkg::REPEAT_WIDTH-1:0] rpt_ff, rpt_in;
   logic                             ev_armed, ev_on, ev_off;

   // one tick of sequencing, in the order the rules apply
   always_comb begin
      armed_in     = armed_ff;
      exit_run_in  = exit_run_ff;
      exit_el_in   = exit_el_ff;
      entry_run_in = entry_run_ff;
      entry_rem_in = entry_rem_ff;
      siren_in     = siren_ff;
      cycle_in     = cycle_ff;
      siren_el_in  = siren_el_ff;
      rpt_in       = rpt_ff;
      ev_armed     = 1'b0;
      ev_on        = 1'b0;
      ev_off       = 1'b0;

      // timers advance, elapsed counters saturate
      if (exit_run_ff && exit_el_ff != TIMER_MAX) exit_el_in = exit_el_ff + 1'b1;
      if (entry_run_ff && entry_rem_ff != '0) entry_rem_in = entry_rem_ff - 1'b1;
      if (siren_ff && siren_el_ff != TIMER_MAX) siren_el_in = siren_el_ff + 1'b1;

      // disarm clears everything
      if (item.disarm_cmd) begin
         armed_in     = 1'b0;
         exit_run_in  = 1'b0;
         exit_el_in   = '0;
         entry_run_in = 1'b0;
         entry_rem_in = '0;
         siren_in     = 1'b0;
         cycle_in     = 1'b0;
         siren_el_in  = '0;
         rpt_in       = '0;
         ev_off       = 1'b1;
      end

      // start (or restart) the exit delay
      if (item.start_cmd && !armed_in) begin
         exit_run_in = 1'b1;
         exit_el_in  = '0;
      end

      // sensor activity holds the exit delay at zero
      if (item.sensor_active && !armed_in && exit_run_in && !entry_run_in && !cycle_in)
         exit_el_in = '0;

      // exit delay expiry arms the system
      if (exit_run_in && exit_el_in > exit_delay) begin
         armed_in    = 1'b1;
         exit_run_in = 1'b0;
         exit_el_in  = '0;
         ev_armed    = 1'b1;
      end

      // trigger while armed starts the entry delay
      if (item.sensor_active && armed_in && !entry_run_in && !cycle_in) begin
         entry_run_in = 1'b1;
         entry_rem_in = {1'b0, entry_delay} + 1'b1;
      end

      // entry delay done: siren burst starts
      if (armed_in && entry_run_in && entry_rem_in == '0) begin
         entry_run_in = 1'b0;
         siren_in     = 1'b1;
         siren_el_in  = '0;
         cycle_in     = 1'b1;
         ev_on        = 1'b1;
      end

      // burst end: schedule a repeat or close the alarm cycle
      if (siren_in && !entry_run_in && siren_el_in > siren_time) begin
         siren_in    = 1'b0;
         siren_el_in = '0;
         ev_off      = 1'b1;
         if (rpt_in < repeat_limit) begin
            entry_run_in = 1'b1;
            entry_rem_in = {1'b0, entry_delay} + {1'b0, repeat_pause} + 1'b1;
            rpt_in       = rpt_in + 1'b1;
         end else begin
            cycle_in = 1'b0;
            rpt_in   = '0;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         exit_run_ff  <= 1'b0;
         exit_el_ff   <= '0;
         entry_run_ff <= 1'b0;
         entry_rem_ff <= '0;
         siren_ff     <= 1'b0;
         cycle_ff     <= 1'b0;
         siren_el_ff  <= '0;
         rpt_ff       <= '0;
      end else if (step_en) begin
         armed_ff     <= armed_in;
         exit_run_ff  <= exit_run_in;
         exit_el_ff   <= exit_el_in;
         entry_run_ff <= entry_run_in;
         entry_rem_ff <= entry_rem_in;
         siren_ff     <= siren_in;
         cycle_ff     <= cycle_in;
         siren_el_ff  <= siren_el_in;
         rpt_ff       <= rpt_in;
      end
   end

   assign result.siren               = siren_in;
   assign result.armed               = armed_in;
   assign result.armed_event         = ev_armed;
   assign result.intrusion_on_event  = ev_on;
   assign result.intrusion_off_event = ev_off;
   assign result.repeats_done        = rpt_in;

   assign armed_state = armed_ff;
   assign entry_state = entry_run_ff;
   assign siren_state = siren_ff;

endmodule

`default_nettype wire

### tb/ias_checker.sv
// ----------------------------------------------------------------------------
// ias_checker: result predictor and scoreboard for the alarm sequencer
// Watches the item, result and register-write ports of the sequencer, keeps
// its own copy of the timers, flags and timing registers, predicts one result
// per accepted tick and compares each returned result field by field.
// ----------------------------------------------------------------------------

module ias_checker #(
   parameter int unsigned TIMER_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   // [0] sensor_active, [1] start_cmd, [2] disarm_cmd, [7:3] zero
   input  logic [ias_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] siren, [1] armed, [2] armed_event, [3] intrusion_on_event,
   // [4] intrusion_off_event, [8:5] repeats_done, [15:9] zero
   input  logic [ias_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   input  logic                                  csr_we,
   input  logic [ias_pkg::CSR_ADDR_WIDTH-1:0]    csr_waddr,
   input  logic [TIMER_WIDTH-1:0]                csr_wdata,
   output int unsigned                           error_count,
   output int unsigned                           pending_count,
   output int unsigned                           arm_count,
   output int unsigned                           burst_count,
   output logic [ias_pkg::REPEAT_WIDTH-1:0]      deepest_repeat
);
   import ias_pkg::*;

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
   localparam int unsigned ITEM_BITS = $bits(rsp_item_type);

   // timing registers
   logic [TIMER_WIDTH-1:0]  cfg_exit, cfg_entry, cfg_siren, cfg_pause;
   logic [REPEAT_WIDTH-1:0] cfg_limit;

   // sequencer state
   logic                    is_armed, exit_run, entry_run, siren_q, cycle_q;
   logic [TIMER_WIDTH-1:0]  exit_ms, siren_ms;
   logic [TIMER_WIDTH:0]    entry_left;
   logic [REPEAT_WIDTH-1:0] rep_cnt;

   // predicted results, oldest first
   rsp_item_type            alarm_q[$];

   initial begin
      error_count    = 0;
      pending_count  = 0;
      arm_count      = 0;
      burst_count    = 0;
      deepest_repeat = '0;
   end

   // everything a disarm clears
   task clear_state();
      is_armed   = 1'b0;
      exit_run   = 1'b0;
      exit_ms    = '0;
      entry_run  = 1'b0;
      entry_left = '0;
      siren_q    = 1'b0;
      cycle_q    = 1'b0;
      siren_ms   = '0;
      rep_cnt    = '0;
   endtask

   // one millisecond tick of the sequencer
   task step_alarm(input req_item_type tick, output rsp_item_type res);
      logic ev_armed, ev_on, ev_off;
      ev_armed = 1'b0;
      ev_on    = 1'b0;
      ev_off   = 1'b0;

      // running timers advance; elapsed counters stick at all ones
      if (exit_run && exit_ms != TIMER_MAX) exit_ms = exit_ms + 1'b1;
      if (entry_run && entry_left != '0) entry_left = entry_left - 1'b1;
      if (siren_q && siren_ms != TIMER_MAX) siren_ms = siren_ms + 1'b1;

      if (tick.disarm_cmd) begin
         clear_state();
         ev_off = 1'b1;
      end

      if (tick.start_cmd && !is_armed) begin
         exit_run = 1'b1;
         exit_ms  = '0;
      end

      // sensor activity restarts the exit delay
      if (tick.sensor_active && !is_armed && exit_run && !entry_run && !cycle_q)
         exit_ms = '0;

      if (exit_run && exit_ms > cfg_exit) begin
         is_armed = 1'b1;
         exit_run = 1'b0;
         exit_ms  = '0;
         ev_armed = 1'b1;
      end

      // trigger of the entry delay; ignored during an alarm cycle
      if (tick.sensor_active && is_armed && !entry_run && !cycle_q) begin
         entry_run  = 1'b1;
         entry_left = {1'b0, cfg_entry} + 1'b1;
      end

      if (is_armed && entry_run && entry_left == '0) begin
         entry_run = 1'b0;
         siren_q   = 1'b1;
         siren_ms  = '0;
         cycle_q   = 1'b1;
         ev_on     = 1'b1;
      end

      // burst end: schedule a repeat or close the cycle
      if (siren_q && !entry_run && siren_ms > cfg_siren) begin
         siren_q  = 1'b0;
         siren_ms = '0;
         ev_off   = 1'b1;
         if (rep_cnt < cfg_limit) begin
            entry_run  = 1'b1;
            entry_left = {1'b0, cfg_entry} + {1'b0, cfg_pause} + 1'b1;
            rep_cnt    = rep_cnt + 1'b1;
         end else begin
            cycle_q = 1'b0;
            rep_cnt = '0;
         end
      end

      res.siren               = siren_q;
      res.armed               = is_armed;
      res.armed_event         = ev_armed;
      res.intrusion_on_event  = ev_on;
      res.intrusion_off_event = ev_off;
      res.repeats_done        = rep_cnt;
   endtask

   task check_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   // monitor: results are matched before new items are predicted
   always @(posedge clock) begin : monitor
      rsp_item_type want, got;
      req_item_type tick;
      if (reset) begin
         cfg_exit  = EXIT_DELAY_RST[TIMER_WIDTH-1:0];
         cfg_entry = ENTRY_DELAY_RST[TIMER_WIDTH-1:0];
         cfg_siren = SIREN_TIME_RST[TIMER_WIDTH-1:0];
         cfg_pause = REPEAT_PAUSE_RST[TIMER_WIDTH-1:0];
         cfg_limit = REPEAT_LIMIT_RST;
         clear_state();
         alarm_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata[ITEM_BITS-1:0]);
            if (alarm_q.size() == 0) begin
               $error("result item 0x%0h arrived with no item outstanding", rsp_tdata);
               error_count++;
            end else begin
               want = alarm_q.pop_front();
               check_field("siren", 32'(want.siren), 32'(got.siren));
               check_field("armed", 32'(want.armed), 32'(got.armed));
               check_field("armed_event", 32'(want.armed_event), 32'(got.armed_event));
               check_field("intrusion_on_event", 32'(want.intrusion_on_event),
                           32'(got.intrusion_on_event));
               check_field("intrusion_off_event", 32'(want.intrusion_off_event),
                           32'(got.intrusion_off_event));
               check_field("repeats_done", 32'(want.repeats_done), 32'(got.repeats_done));
               check_field("pad", 0, 32'(rsp_tdata[RSP_DATA_WIDTH-1:ITEM_BITS]));
            end
         end

         if (req_tvalid && req_tready) begin
            tick = req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
            step_alarm(tick, want);
            alarm_q.push_back(want);
            if (want.armed_event) arm_count++;
            if (want.intrusion_on_event) burst_count++;
            if (want.repeats_done > deepest_repeat) deepest_repeat = want.repeats_done;
         end

         // register writes land at the same edge as the DUT takes them
         if (csr_we) begin
            case (csr_index_type'(csr_waddr))
               CSR_EXIT_DELAY:   cfg_exit  = csr_wdata;
               CSR_ENTRY_DELAY:  cfg_entry = csr_wdata;
               CSR_SIREN_TIME:   cfg_siren = csr_wdata;
               CSR_REPEAT_PAUSE: cfg_pause = csr_wdata;
               CSR_REPEAT_LIMIT: cfg_limit = csr_wdata[REPEAT_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= alarm_q.size();
   end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the intruder alarm sequencer
// Drives millisecond ticks in bursts with random gaps, stalls the result side
// on a rotating pattern, and steps the timing registers through short, zero
// and all-ones settings between drained phases. A separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------

module tb_top;
   import ias_pkg::*;

   localparam int unsigned TW = 24;
   localparam logic [TW-1:0] TIMER_MAX = '1;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_we     = 1'b0;
   csr_index_type             csr_waddr  = CSR_EXIT_DELAY;
   logic [TW-1:0]             csr_wdata  = '0;

   int unsigned               error_count, pending_count, arm_count, burst_count;
   logic [REPEAT_WIDTH-1:0]   deepest_repeat;

   int unsigned               items_sent     = 0;
   int unsigned               settings_used  = 0;
   int unsigned               burst_left     = 0;
   int unsigned               rx_cycle       = 0;
   logic [TW-1:0]             cur_exit       = '0;

   intruder_alarm_sequencer #(.TIMER_WIDTH(TW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_waddr  (csr_waddr),
      .csr_wdata  (csr_wdata)
   );

   ias_checker #(.TIMER_WIDTH(TW)) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_waddr      (csr_waddr),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .arm_count      (arm_count),
      .burst_count    (burst_count),
      .deepest_repeat (deepest_repeat)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: always ready, random, periodic, then long random stalls
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[8:7])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (rx_cycle[2:0] > 3'd2);
         default: rsp_tready <= ($urandom_range(0, 7) == 0) ? ~rsp_tready : rsp_tready;
      endcase
   end

   // one tick item; opens a new burst with an optional gap when due
   task automatic send_tick(input logic sensor, input logic start, input logic disarm);
      int unsigned  gap;
      req_item_type tick;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      tick.sensor_active = sensor;
      tick.start_cmd     = start;
      tick.disarm_cmd    = disarm;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_WIDTH'(tick);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // hold off input until every predicted result is back, or the wait times out
   task automatic wait_drained();
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [TW-1:0] value);
      csr_we    <= 1'b1;
      csr_waddr <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [TW-1:0] exit_ms, input logic [TW-1:0] entry_ms,
                             input logic [TW-1:0] siren_ms, input logic [TW-1:0] pause_ms,
                             input logic [REPEAT_WIDTH-1:0] limit);
      write_reg(CSR_EXIT_DELAY, exit_ms);
      write_reg(CSR_ENTRY_DELAY, entry_ms);
      write_reg(CSR_SIREN_TIME, siren_ms);
      write_reg(CSR_REPEAT_PAUSE, pause_ms);
      write_reg(CSR_REPEAT_LIMIT, TW'(limit));
      csr_we <= 1'b0;
      cur_exit = exit_ms;
      settings_used++;
   endtask

   // mostly a full arm / trigger / alarm sequence, sometimes plain noise
   task automatic run_sequence();
      int unsigned quiet, tail, noise;
      if ($urandom_range(0, 4) != 0) begin
         if ($urandom_range(0, 1) != 0) begin
            send_tick(1'b0, 1'b1, 1'b1);
         end else begin
            send_tick(1'b0, 1'b0, 1'b1);
            send_tick(1'b0, 1'b1, 1'b0);
         end
         quiet = (cur_exit > 10) ? 12 : cur_exit + $urandom_range(1, 3);
         repeat (quiet) send_tick($urandom_range(0, 9) == 0, 1'b0, 1'b0);
         send_tick(1'b1, 1'b0, 1'b0);
         tail = $urandom_range(5, 40);
         repeat (tail) begin
            send_tick($urandom_range(0, 4) == 0, $urandom_range(0, 19) == 0,
                      $urandom_range(0, 59) == 0);
         end
      end else begin
         noise = $urandom_range(3, 15);
         repeat (noise) begin
            send_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                      $urandom_range(0, 3) == 0);
         end
      end
   endtask

   // main stimulus
   initial begin : stimulus
      int unsigned phase, quota, phase_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: all-zero timing so every phase moves one tick at a time
      set_timing('0, '0, '0, '0, 4'd3);
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b1, 1'b1);   // disarm, start and sensor together
      send_tick(1'b0, 1'b1, 1'b0);   // start while exit delay runs
      send_tick(1'b0, 1'b0, 1'b0);   // arms
      send_tick(1'b0, 1'b1, 1'b0);   // start while armed is ignored
      send_tick(1'b1, 1'b0, 1'b0);   // trigger entry delay
      send_tick(1'b0, 1'b0, 1'b0);   // first burst
      send_tick(1'b1, 1'b0, 1'b0);   // sensor in alarm cycle ignored, repeat
      send_tick(1'b1, 1'b0, 1'b0);   // second burst starts
      // repeat limit dropped under the repeat count mid-cycle
      wait_drained();
      write_reg(CSR_REPEAT_LIMIT, '0);
      csr_we <= 1'b0;
      send_tick(1'b0, 1'b0, 1'b0);   // burst ends and cycle closes
      send_tick(1'b1, 1'b1, 1'b0);   // re-trigger, start ignored
      send_tick(1'b0, 1'b0, 1'b1);   // disarm during entry delay
      send_tick(1'b0, 1'b1, 1'b1);
      send_tick(1'b1, 1'b0, 1'b1);
      send_tick(1'b1, 1'b1, 1'b0);   // sensor restarts the fresh exit delay
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);

      // random phases, each under its own timing
      for (phase = 0; phase < 9; phase++) begin
         wait_drained();
         case (phase)
            2: set_timing(TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX, 4'hF);
            4: set_timing('0, '0, '0, '0, 4'd0);
            6: set_timing(TW'(1), TW'(2), TIMER_MAX, TIMER_MAX, 4'hF);
            default: begin
               set_timing(TW'($urandom_range(0, 6)), TW'($urandom_range(0, 4)),
                          TW'($urandom_range(0, 6)), TW'($urandom_range(0, 4)),
                          ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom_range(0, 3)));
            end
         endcase
         quota = (phase == 2) ? 20 : 28;
         phase_start = items_sent;
         while (items_sent - phase_start < quota) run_sequence();
      end

      wait_drained();
      repeat (6) @(posedge clock);
      $display("Run covered %0d ticks under %0d timing settings, incl. zero and all-ones.",
               items_sent, settings_used);
      $display("Predicted %0d arming events and %0d siren bursts, deepest repeat count %0d.",
               arm_count, burst_count, deepest_repeat);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // hard stop if the handshake hangs
   initial begin
      #3000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

### files.f
src/ias_pkg.sv
src/ias_csr.sv
src/ias_core.sv
src/intruder_alarm_sequencer.sv
tb/ias_checker.sv
tb/tb_top.sv
